[src/adsr_pkg.sv]
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types and fixed widths of the linear ADSR envelope generator
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int POS_W       = 28;
  localparam int NOTE_W      = 26;
  localparam int KIND_W      = 2;
  localparam int PHASE_W     = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_RESET   = 2'd3
  } kind_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_RELEASE = 2'd2,
    REG_SUSTAIN = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LEV_ZERO = 2'd0,
    LEV_SUST = 2'd1,
    LEV_QUOT = 2'd2,
    LEV_INV  = 2'd3
  } level_op_t;

  typedef enum logic [1:0] {
    CTL_IDLE   = 2'd0,
    CTL_CALC   = 2'd1,
    CTL_FINISH = 2'd2
  } ctl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE = 2'd0,
    MD_MUL  = 2'd1,
    MD_DIV  = 2'd2
  } md_state_t;

endpackage

`default_nettype wire

[src/adsr_muldiv.sv]
// ----------------------------------------------------------------------------
// adsr_muldiv
// bit-serial shift-add multiply followed by restoring divide, saturated quotient
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_muldiv #(
  parameter int A_W = 28,
  parameter int B_W = 17,
  parameter int D_W = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [A_W-1:0] a,
  input  wire logic [B_W-1:0] b,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [B_W-1:0]      quot_sat
);

  localparam int PROD_W = A_W + B_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam logic [B_W-1:0] ONE_LEVEL = {1'b1, {(B_W-1){1'b0}}};

  adsr_pkg::md_state_t state;
  adsr_pkg::md_state_t state_next;

  logic [PROD_W-1:0] mcand;
  logic [B_W-1:0]    mplier;
  logic [PROD_W-1:0] prod;
  logic [D_W-1:0]    dvs;
  logic [D_W-1:0]    rem;
  logic [B_W-1:0]    quot;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;
  logic              done_next;
  logic [D_W:0]      trial;
  logic              trial_ge;

  assign trial    = {rem, prod[PROD_W-1]};
  assign trial_ge = trial >= {1'b0, dvs};
  assign quot_sat = (ovf || quot > ONE_LEVEL) ? ONE_LEVEL : quot;

  always_comb begin
    state_next = state;
    unique case (state)
      adsr_pkg::MD_IDLE: begin
        if (start) state_next = adsr_pkg::MD_MUL;
      end
      adsr_pkg::MD_MUL: begin
        if (cnt == '0) state_next = adsr_pkg::MD_DIV;
      end
      adsr_pkg::MD_DIV: begin
        if (cnt == '0) state_next = adsr_pkg::MD_IDLE;
      end
      default: state_next = adsr_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    done_next = (state == adsr_pkg::MD_DIV) && (cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adsr_pkg::MD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      adsr_pkg::MD_IDLE: begin
        if (start) begin
          mcand  <= PROD_W'(a);
          mplier <= b;
          dvs    <= divisor;
          prod   <= '0;
          rem    <= '0;
          quot   <= '0;
          ovf    <= 1'b0;
          cnt    <= CNT_W'(B_W - 1);
        end
      end
      adsr_pkg::MD_MUL: begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= (cnt == '0) ? CNT_W'(PROD_W - 1) : cnt - CNT_W'(1);
      end
      adsr_pkg::MD_DIV: begin
        rem  <= trial_ge ? D_W'(trial - {1'b0, dvs}) : trial[D_W-1:0];
        prod <= prod << 1;
        quot <= {quot[B_W-2:0], trial_ge};
        ovf  <= ovf | quot[B_W-1];
        cnt  <= cnt - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[src/adsr_envelope_generator.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// linear attack, decay, sustain and release envelope, one level per tick
// ----------------------------------------------------------------------------
// Items enter on the s_ stream: a tick, a note trigger with its length, a note
// release or a reset. Only a tick gives a result, a level in unsigned fixed
// point with LEVEL_FRAC_BITS fraction bits plus its phase, on the m_ stream;
// m_tlast marks that the envelope has come back to idle. Attack, decay and
// release ticks run one shared bit-serial unit: LEVEL_FRAC_BITS+1 shift-add
// steps, then max(28, LEN_BITS)+LEVEL_FRAC_BITS+1 restoring divide steps.
// Sustain and idle ticks, and a release tick that ends the fade, skip that
// unit. A finished result waits in the output register while the next item
// is taken. Registers are written over the APB port at 4*index.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator #(
  parameter int LEN_BITS        = 24,
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // slave stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [adsr_pkg::IN_TDATA_W-1:0]     s_tdata,  // note_length
  input  wire logic [adsr_pkg::KIND_W-1:0]         s_tuser,  // kind
  // master stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [((LEVEL_FRAC_BITS+8)/8)*8-1:0]     m_tdata,  // level
  output logic [adsr_pkg::PHASE_W-1:0]             m_tuser,  // phase
  output logic                                     m_tlast,  // finished
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [adsr_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [adsr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [adsr_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  localparam int LEVEL_W    = LEVEL_FRAC_BITS + 1;
  localparam int OUT_DATA_W = ((LEVEL_FRAC_BITS + 8) / 8) * 8;
  localparam int POS_W      = adsr_pkg::POS_W;
  localparam int NOTE_W     = adsr_pkg::NOTE_W;
  localparam int A_W        = (POS_W > LEN_BITS) ? POS_W : LEN_BITS;
  localparam int CMP_W      = A_W + 1;
  localparam int SUM_W      = LEN_BITS + 2;
  localparam int TRIG_W     = (SUM_W > NOTE_W) ? SUM_W : NOTE_W;
  localparam logic [LEVEL_W-1:0] ONE_LEVEL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  // configuration registers
  logic [LEN_BITS-1:0] attack_len;
  logic [LEN_BITS-1:0] decay_len;
  logic [LEN_BITS-1:0] release_len;
  logic [LEVEL_W-1:0]  sustain_level;

  // envelope state
  adsr_pkg::phase_t    phase;
  logic [POS_W-1:0]    position;
  logic [NOTE_W-1:0]   sustain_count;
  logic [POS_W-1:0]    release_begin;
  logic [LEVEL_W-1:0]  held_level;

  // control
  adsr_pkg::ctl_state_t ctl_state;
  adsr_pkg::ctl_state_t ctl_state_next;
  adsr_pkg::level_op_t  op;
  logic                 held_upd;
  logic                 accept;
  logic                 md_start;
  logic                 md_done;
  logic                 out_load;
  logic                 cfg_write;

  // output register
  logic [LEVEL_W-1:0]  out_level;
  adsr_pkg::phase_t    out_phase;
  logic                out_last;

  // decode
  adsr_pkg::kind_t     kind;
  logic [NOTE_W-1:0]   note_length;
  logic [LEN_BITS-1:0] eff_attack;
  logic [LEN_BITS-1:0] eff_decay;
  logic [LEN_BITS-1:0] eff_release;
  logic [LEVEL_W-1:0]  eff_sustain;
  logic [TRIG_W-1:0]   other_sum;
  logic [TRIG_W-1:0]   note_ext;
  logic [NOTE_W-1:0]   trig_count;
  logic [CMP_W-1:0]    pos_inc;
  logic [POS_W-1:0]    rel_dist;
  logic [CMP_W-1:0]    rel_dist_inc;

  adsr_pkg::level_op_t tick_op;
  adsr_pkg::phase_t    tick_phase;
  logic [POS_W-1:0]    tick_pos;
  logic                tick_held_upd;
  logic [A_W-1:0]      md_a;
  logic [LEVEL_W-1:0]  md_b;
  logic [LEN_BITS-1:0] md_div;
  logic [LEVEL_W-1:0]  md_quot;
  logic [LEVEL_W-1:0]  level_calc;

  assign kind        = adsr_pkg::kind_t'(s_tuser);
  assign note_length = s_tdata[NOTE_W-1:0];
  assign eff_attack  = (attack_len == '0) ? LEN_BITS'(1) : attack_len;
  assign eff_decay   = (decay_len == '0) ? LEN_BITS'(1) : decay_len;
  assign eff_release = (release_len == '0) ? LEN_BITS'(1) : release_len;
  assign eff_sustain = (sustain_level > ONE_LEVEL) ? ONE_LEVEL : sustain_level;

  assign other_sum  = TRIG_W'(eff_attack) + TRIG_W'(eff_decay) + TRIG_W'(eff_release);
  assign note_ext   = TRIG_W'(note_length);
  assign trig_count = (note_ext > other_sum) ? NOTE_W'(note_ext - other_sum) : '0;

  assign pos_inc      = CMP_W'(position) + CMP_W'(1);
  assign rel_dist     = position - release_begin;
  assign rel_dist_inc = CMP_W'(rel_dist) + CMP_W'(1);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // per-tick decisions from the current phase
  always_comb begin
    tick_op       = adsr_pkg::LEV_ZERO;
    tick_phase    = adsr_pkg::PH_IDLE;
    tick_pos      = position;
    tick_held_upd = 1'b0;
    md_a          = A_W'(position);
    md_b          = ONE_LEVEL;
    md_div        = eff_attack;
    unique case (phase)
      adsr_pkg::PH_ATTACK: begin
        tick_op       = adsr_pkg::LEV_QUOT;
        tick_held_upd = 1'b1;
        if (pos_inc >= CMP_W'(eff_attack)) begin
          tick_phase = adsr_pkg::PH_DECAY;
          tick_pos   = '0;
        end else begin
          tick_phase = adsr_pkg::PH_ATTACK;
          tick_pos   = pos_inc[POS_W-1:0];
        end
      end
      adsr_pkg::PH_DECAY: begin
        tick_op       = adsr_pkg::LEV_INV;
        tick_held_upd = 1'b1;
        md_b          = ONE_LEVEL - eff_sustain;
        md_div        = eff_decay;
        if (pos_inc >= CMP_W'(eff_decay)) begin
          tick_phase = adsr_pkg::PH_SUSTAIN;
          tick_pos   = '0;
        end else begin
          tick_phase = adsr_pkg::PH_DECAY;
          tick_pos   = pos_inc[POS_W-1:0];
        end
      end
      adsr_pkg::PH_SUSTAIN: begin
        tick_op       = adsr_pkg::LEV_SUST;
        tick_held_upd = 1'b1;
        tick_pos      = pos_inc[POS_W-1:0];
        tick_phase    = (pos_inc >= CMP_W'(sustain_count)) ? adsr_pkg::PH_IDLE
                                                           : adsr_pkg::PH_SUSTAIN;
      end
      adsr_pkg::PH_RELEASE: begin
        tick_pos = pos_inc[POS_W-1:0];
        md_a     = A_W'(CMP_W'(eff_release) - CMP_W'(rel_dist));
        md_b     = held_level;
        md_div   = eff_release;
        if (rel_dist_inc >= CMP_W'(eff_release)) begin
          tick_op    = adsr_pkg::LEV_ZERO;
          tick_phase = adsr_pkg::PH_IDLE;
        end else begin
          tick_op    = adsr_pkg::LEV_QUOT;
          tick_phase = adsr_pkg::PH_RELEASE;
        end
      end
      default: begin
        tick_op    = adsr_pkg::LEV_ZERO;
        tick_phase = adsr_pkg::PH_IDLE;
      end
    endcase
  end

  adsr_muldiv #(
    .A_W (A_W),
    .B_W (LEVEL_W),
    .D_W (LEN_BITS)
  ) u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (md_start),
    .a        (md_a),
    .b        (md_b),
    .divisor  (md_div),
    .done     (md_done),
    .quot_sat (md_quot)
  );

  always_comb begin
    unique case (op)
      adsr_pkg::LEV_ZERO: level_calc = '0;
      adsr_pkg::LEV_SUST: level_calc = eff_sustain;
      adsr_pkg::LEV_QUOT: level_calc = md_quot;
      adsr_pkg::LEV_INV:  level_calc = ONE_LEVEL - md_quot;
    endcase
  end

  // control: next state
  always_comb begin
    ctl_state_next = ctl_state;
    unique case (ctl_state)
      adsr_pkg::CTL_IDLE: begin
        if (accept && kind == adsr_pkg::KIND_TICK) begin
          ctl_state_next = md_start ? adsr_pkg::CTL_CALC : adsr_pkg::CTL_FINISH;
        end
      end
      adsr_pkg::CTL_CALC: begin
        if (md_done) ctl_state_next = adsr_pkg::CTL_FINISH;
      end
      adsr_pkg::CTL_FINISH: begin
        if (out_load) ctl_state_next = adsr_pkg::CTL_IDLE;
      end
      default: ctl_state_next = adsr_pkg::CTL_IDLE;
    endcase
  end

  // control: outputs
  always_comb begin
    s_tready = (ctl_state == adsr_pkg::CTL_IDLE);
    accept   = s_tvalid && s_tready;
    md_start = accept && (kind == adsr_pkg::KIND_TICK) &&
               (tick_op == adsr_pkg::LEV_QUOT || tick_op == adsr_pkg::LEV_INV);
    out_load = (ctl_state == adsr_pkg::CTL_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_state <= adsr_pkg::CTL_IDLE;
      m_tvalid  <= 1'b0;
    end else begin
      ctl_state <= ctl_state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len    <= LEN_BITS'(1);
      decay_len     <= LEN_BITS'(1);
      release_len   <= LEN_BITS'(1);
      sustain_level <= '0;
    end else if (cfg_write) begin
      unique case (adsr_pkg::cfg_reg_t'(paddr[3:2]))
        adsr_pkg::REG_ATTACK:  attack_len    <= pwdata[LEN_BITS-1:0];
        adsr_pkg::REG_DECAY:   decay_len     <= pwdata[LEN_BITS-1:0];
        adsr_pkg::REG_RELEASE: release_len   <= pwdata[LEN_BITS-1:0];
        adsr_pkg::REG_SUSTAIN: sustain_level <= pwdata[LEVEL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (adsr_pkg::cfg_reg_t'(paddr[3:2]))
      adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::APB_DATA_W'(attack_len);
      adsr_pkg::REG_DECAY:   prdata = adsr_pkg::APB_DATA_W'(decay_len);
      adsr_pkg::REG_RELEASE: prdata = adsr_pkg::APB_DATA_W'(release_len);
      adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::APB_DATA_W'(sustain_level);
    endcase
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= adsr_pkg::PH_IDLE;
      position      <= '0;
      sustain_count <= '0;
      release_begin <= '0;
      held_level    <= '0;
    end else begin
      if (accept) begin
        unique case (kind)
          adsr_pkg::KIND_TICK: begin
            phase    <= tick_phase;
            position <= tick_pos;
          end
          adsr_pkg::KIND_TRIGGER: begin
            sustain_count <= trig_count;
            phase         <= adsr_pkg::PH_ATTACK;
            position      <= '0;
            held_level    <= '0;
          end
          adsr_pkg::KIND_RELEASE: begin
            if (phase != adsr_pkg::PH_IDLE) begin
              release_begin <= position;
              phase         <= adsr_pkg::PH_RELEASE;
            end
          end
          adsr_pkg::KIND_RESET: begin
            phase      <= adsr_pkg::PH_IDLE;
            position   <= '0;
            held_level <= '0;
          end
        endcase
      end else if (out_load && held_upd) begin
        held_level <= level_calc;
      end
    end
  end

  // per-tick latches and output register
  always_ff @(posedge clk) begin
    if (accept && kind == adsr_pkg::KIND_TICK) begin
      op       <= tick_op;
      held_upd <= tick_held_upd;
    end
    if (out_load) begin
      out_level <= level_calc;
      out_phase <= phase;
      out_last  <= (phase == adsr_pkg::PH_IDLE);
    end
  end

  assign m_tdata = OUT_DATA_W'(out_level);
  assign m_tuser = out_phase;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

[tb/adsr_envelope_generator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator_test
// self-checking stream and register test of the linear ADSR envelope
// ----------------------------------------------------------------------------
// Items go in on the slave stream and every accepted one steps a behavioural
// envelope kept in the bench; each tick queues the level, phase and finished
// flag it should give. Results on the master stream are checked in order
// against that queue. Directed notes cover idle, zero lengths, saturated
// sustain, release restarts, full-scale lengths and a long output hold, then
// random notes run under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------

module adsr_envelope_generator_test;

  localparam int LEVEL_BITS     = 17;
  localparam int LEN_W          = 24;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 2000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 10;

  localparam longint unsigned ONE_LEVEL = 64'd1 << 16;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    adsr_pkg::phase_t      phase;
    logic                  finished;
  } env_sample_t;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [adsr_pkg::IN_TDATA_W-1:0] s_tdata  = '0;  // note_length
  logic [adsr_pkg::KIND_W-1:0]     s_tuser  = '0;  // kind
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [23:0]                     m_tdata;        // level
  logic [adsr_pkg::PHASE_W-1:0]    m_tuser;        // phase
  logic                            m_tlast;        // finished
  logic                            psel     = 1'b0;
  logic                            penable  = 1'b0;
  logic                            pwrite   = 1'b0;
  logic [adsr_pkg::APB_ADDR_W-1:0] paddr    = '0;
  logic [adsr_pkg::APB_DATA_W-1:0] pwdata   = '0;
  logic [adsr_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  adsr_envelope_generator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // bench copy of the envelope
  logic [LEN_W-1:0]            cfg_attack  = 24'd1;
  logic [LEN_W-1:0]            cfg_decay   = 24'd1;
  logic [LEN_W-1:0]            cfg_release = 24'd1;
  logic [LEVEL_BITS-1:0]       cfg_sustain = '0;
  adsr_pkg::phase_t            env_phase   = adsr_pkg::PH_IDLE;
  logic [adsr_pkg::POS_W-1:0]  env_pos     = '0;
  logic [adsr_pkg::NOTE_W-1:0] sus_count   = '0;
  logic [adsr_pkg::POS_W-1:0]  rel_begin   = '0;
  logic [LEVEL_BITS-1:0]       held_level  = '0;

  env_sample_t level_queue[$];
  env_sample_t head;

  int errors         = 0;
  int quiet_cycles   = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  function automatic longint unsigned len_or_one(input logic [LEN_W-1:0] v);
    return (v == '0) ? 64'd1 : 64'(v);
  endfunction

  function automatic longint unsigned sustain_sat();
    return (64'(cfg_sustain) > ONE_LEVEL) ? ONE_LEVEL : 64'(cfg_sustain);
  endfunction

  task automatic step_envelope(input adsr_pkg::kind_t kind,
                               input logic [adsr_pkg::NOTE_W-1:0] note);
    longint unsigned a, d, r, s, nxt, lvl, span, rp, drop;
    logic [adsr_pkg::POS_W-1:0] rel_gap;
    env_sample_t                res;
    a    = len_or_one(cfg_attack);
    d    = len_or_one(cfg_decay);
    r    = len_or_one(cfg_release);
    s    = sustain_sat();
    lvl  = 0;
    case (kind)
      adsr_pkg::KIND_TRIGGER: begin
        span       = a + d + r;
        sus_count  = (64'(note) > span) ? adsr_pkg::NOTE_W'(64'(note) - span) : '0;
        env_phase  = adsr_pkg::PH_ATTACK;
        env_pos    = '0;
        held_level = '0;
      end
      adsr_pkg::KIND_RELEASE: begin
        if (env_phase != adsr_pkg::PH_IDLE) begin
          rel_begin = env_pos;
          env_phase = adsr_pkg::PH_RELEASE;
        end
      end
      adsr_pkg::KIND_RESET: begin
        env_phase  = adsr_pkg::PH_IDLE;
        env_pos    = '0;
        held_level = '0;
      end
      default: begin
        nxt = 64'(env_pos) + 1;
        case (env_phase)
          adsr_pkg::PH_ATTACK: begin
            lvl = (64'(env_pos) * ONE_LEVEL) / a;
            if (lvl > ONE_LEVEL) lvl = ONE_LEVEL;
            held_level = LEVEL_BITS'(lvl);
            if (nxt >= a) begin
              env_phase = adsr_pkg::PH_DECAY;
              env_pos   = '0;
            end else begin
              env_pos = adsr_pkg::POS_W'(nxt);
            end
          end
          adsr_pkg::PH_DECAY: begin
            drop = ((ONE_LEVEL - s) * 64'(env_pos)) / d;
            if (drop > ONE_LEVEL) drop = ONE_LEVEL;
            lvl = ONE_LEVEL - drop;
            held_level = LEVEL_BITS'(lvl);
            if (nxt >= d) begin
              env_phase = adsr_pkg::PH_SUSTAIN;
              env_pos   = '0;
            end else begin
              env_pos = adsr_pkg::POS_W'(nxt);
            end
          end
          adsr_pkg::PH_SUSTAIN: begin
            lvl = s;
            held_level = LEVEL_BITS'(lvl);
            if (nxt >= 64'(sus_count)) env_phase = adsr_pkg::PH_IDLE;
            env_pos = adsr_pkg::POS_W'(nxt);
          end
          adsr_pkg::PH_RELEASE: begin
            rel_gap = env_pos - rel_begin;
            rp      = 64'(rel_gap);
            if (rp < r) lvl = (64'(held_level) * (r - rp)) / r;
            env_pos = adsr_pkg::POS_W'(nxt);
            if (rp + 1 >= r) begin
              env_phase = adsr_pkg::PH_IDLE;
              lvl = 0;
            end
          end
          default: begin
            env_phase = adsr_pkg::PH_IDLE;
            lvl = 0;
          end
        endcase
        res.level    = LEVEL_BITS'(lvl);
        res.phase    = env_phase;
        res.finished = (env_phase == adsr_pkg::PH_IDLE);
        level_queue.push_back(res);
      end
    endcase
  endtask

  // register writes, transactions on both streams and the result check
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (psel && penable && pwrite && pready) begin
        case (adsr_pkg::cfg_reg_t'(paddr[3:2]))
          adsr_pkg::REG_ATTACK:  cfg_attack  = pwdata[LEN_W-1:0];
          adsr_pkg::REG_DECAY:   cfg_decay   = pwdata[LEN_W-1:0];
          adsr_pkg::REG_RELEASE: cfg_release = pwdata[LEN_W-1:0];
          adsr_pkg::REG_SUSTAIN: cfg_sustain = pwdata[LEVEL_BITS-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (level_queue.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("unexpected result: level %0d phase %0d finished %0b",
                     m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          head = level_queue.pop_front();
          if (m_tdata !== 24'(head.level) || m_tuser !== head.phase ||
              m_tlast !== head.finished) begin
            if (errors < MAX_REPORTS)
              $display("mismatch: expected level %0d phase %0d finished %0b, got %0d %0d %0b",
                       head.level, head.phase, head.finished, m_tdata, m_tuser, m_tlast);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        step_envelope(adsr_pkg::kind_t'(s_tuser), s_tdata[adsr_pkg::NOTE_W-1:0]);
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver with random stalls and an occasional long hold
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      m_tready    <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input adsr_pkg::kind_t kind,
                           input logic [adsr_pkg::NOTE_W-1:0] note);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= adsr_pkg::IN_TDATA_W'(note);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (level_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input adsr_pkg::cfg_reg_t idx,
                           input logic [adsr_pkg::APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [adsr_pkg::APB_DATA_W-1:0] pick_length();
    case ($urandom_range(15))
      0:       return '0;
      1:       return 32'hFF_FFFF;
      2:       return 32'($urandom) & 32'hFF_FFFF;
      default: return 32'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic test_idle_defaults();
    send_item(adsr_pkg::KIND_TICK, '0);
    send_item(adsr_pkg::KIND_RELEASE, '1);
    send_item(adsr_pkg::KIND_TICK, '1);
    // note shorter than the phases, so sustain gives a single sample
    send_item(adsr_pkg::KIND_TRIGGER, '0);
    repeat (4) send_item(adsr_pkg::KIND_TICK, '0);
    wait_idle();
  endtask

  task automatic test_zero_and_saturated();
    write_reg(adsr_pkg::REG_ATTACK, '0);
    write_reg(adsr_pkg::REG_DECAY, '0);
    write_reg(adsr_pkg::REG_RELEASE, 32'd3);
    write_reg(adsr_pkg::REG_SUSTAIN, 32'h1_FFFF);
    send_item(adsr_pkg::KIND_TRIGGER, '1);
    repeat (3) send_item(adsr_pkg::KIND_TICK, '0);
    send_item(adsr_pkg::KIND_RELEASE, '0);
    send_item(adsr_pkg::KIND_TICK, '0);
    // release again during the fade
    send_item(adsr_pkg::KIND_RELEASE, '0);
    repeat (2) send_item(adsr_pkg::KIND_TICK, '0);
    send_item(adsr_pkg::KIND_RESET, '0);
    send_item(adsr_pkg::KIND_TICK, '0);
    wait_idle();
  endtask

  task automatic test_full_scale();
    write_reg(adsr_pkg::REG_ATTACK, 32'hFF_FFFF);
    write_reg(adsr_pkg::REG_DECAY, 32'hFF_FFFF);
    write_reg(adsr_pkg::REG_RELEASE, 32'hFF_FFFF);
    write_reg(adsr_pkg::REG_SUSTAIN, 32'(ONE_LEVEL));
    send_item(adsr_pkg::KIND_TRIGGER, '1);
    repeat (2) send_item(adsr_pkg::KIND_TICK, '0);
    send_item(adsr_pkg::KIND_RELEASE, '0);
    repeat (2) send_item(adsr_pkg::KIND_TICK, '0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    write_reg(adsr_pkg::REG_ATTACK, 32'd4);
    write_reg(adsr_pkg::REG_DECAY, 32'd3);
    write_reg(adsr_pkg::REG_RELEASE, 32'd5);
    write_reg(adsr_pkg::REG_SUSTAIN, 32'd30000);
    send_item(adsr_pkg::KIND_TRIGGER, 26'd40);
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 30; i++) begin
      if (i == 20) send_item(adsr_pkg::KIND_RELEASE, '0);
      send_item(adsr_pkg::KIND_TICK, '0);
    end
    wait_idle();
  endtask

  task automatic test_random_notes(input int send_pct, input int recv_pct, input int count);
    int stop_at, next_cfg, ticks, rel_at, choice;
    longint unsigned span;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at  = items_sent + count;
    next_cfg = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        wait_idle();
        write_reg(adsr_pkg::REG_ATTACK, pick_length());
        write_reg(adsr_pkg::REG_DECAY, pick_length());
        write_reg(adsr_pkg::REG_RELEASE, pick_length());
        case ($urandom_range(7))
          0:       write_reg(adsr_pkg::REG_SUSTAIN, '0);
          1:       write_reg(adsr_pkg::REG_SUSTAIN, 32'(ONE_LEVEL));
          2:       write_reg(adsr_pkg::REG_SUSTAIN, 32'($urandom) & 32'h1_FFFF);
          default: write_reg(adsr_pkg::REG_SUSTAIN, 32'($urandom_range(0, 65536)));
        endcase
        next_cfg = items_sent + $urandom_range(30, 90);
      end
      choice = $urandom_range(99);
      if (choice < 85) begin
        span = len_or_one(cfg_attack) + len_or_one(cfg_decay) + len_or_one(cfg_release);
        if ($urandom_range(3) == 0)
          send_item(adsr_pkg::KIND_TRIGGER, adsr_pkg::NOTE_W'($urandom));
        else
          send_item(adsr_pkg::KIND_TRIGGER,
                    adsr_pkg::NOTE_W'(span + $urandom_range(0, 12)));
        ticks  = $urandom_range(1, 40);
        rel_at = $urandom_range(0, ticks + 8);
        for (int i = 0; i < ticks; i++) begin
          if (i == rel_at) send_item(adsr_pkg::KIND_RELEASE, adsr_pkg::NOTE_W'($urandom));
          if (i == rel_at + 3 && $urandom_range(3) == 0)
            send_item(adsr_pkg::KIND_RELEASE, adsr_pkg::NOTE_W'($urandom));
          send_item(adsr_pkg::KIND_TICK, adsr_pkg::NOTE_W'($urandom));
        end
      end else if (choice < 92) begin
        send_item(adsr_pkg::KIND_RESET, adsr_pkg::NOTE_W'($urandom));
        repeat ($urandom_range(1, 3))
          send_item(adsr_pkg::KIND_TICK, adsr_pkg::NOTE_W'($urandom));
      end else begin
        send_item(adsr_pkg::kind_t'($urandom_range(3)), adsr_pkg::NOTE_W'($urandom));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_defaults();
    test_zero_and_saturated();
    test_full_scale();
    test_output_backpressure();
    test_random_notes(0, 0, 300);
    test_random_notes(80, 0, 300);
    test_random_notes(0, 80, 300);
    test_random_notes(15, 15, 300);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
src/adsr_pkg.sv
src/adsr_muldiv.sv
src/adsr_envelope_generator.sv
tb/adsr_envelope_generator_test.sv
